// ===== hdl/wsp_pkg.sv =====
package wsp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SIG,
        PH_CHDR,
        PH_FMT,
        PH_FMTX,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } t_phase;

    // Sample count computation at the data chunk header
    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_DIV,
        CALC_MUL,
        CALC_EMIT
    } t_calc;

    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [2:0] ERR_RIFF    = 3'd0;
    localparam logic [2:0] ERR_WAVE    = 3'd1;
    localparam logic [2:0] ERR_EXT     = 3'd2;
    localparam logic [2:0] ERR_NO_FMT  = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM = 3'd4;
    localparam logic [2:0] ERR_BITS    = 3'd5;
    localparam logic [2:0] ERR_NO_CH   = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_EXT  = 16'hFFFE;
    localparam logic [15:0] EXT_SIZE = 16'd22;
    localparam logic [15:0] BITS_16  = 16'd16;

    // One queued input byte
    typedef struct packed {
        logic       file_start;
        logic [7:0] data_byte;
    } t_item;

    // One result item
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic [31:0]        sample_rate;
        logic [15:0]        channel_count;
        logic [2:0]         error_code;
        logic               last_sample;
    } t_result;

    // Replace the low or high byte of a 16-bit field
    function automatic logic [15:0] put16(input logic [15:0] v, input logic odd,
                                          input logic [7:0] b);
        logic [15:0] r;
        r = odd ? {b, v[7:0]} : {v[15:8], b};
        return r;
    endfunction

endpackage

// ===== hdl/wsp_fifo.sv =====
module wsp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  wsp_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_pop,
    output wsp_pkg::t_item   o_item
);

    wsp_pkg::t_item r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       push;

    assign o_stall = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && !o_stall;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, i_pop};
        end
    end

endmodule

// ===== hdl/wsp_div.sv =====
module wsp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic [17:0] r_rem;
    logic [31:0] r_quo;
    logic [16:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [17:0] shifted;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign shifted    = {r_rem[16:0], r_quo[31]};
    assign fits       = (shifted >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 18'd0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_rem <= fits ? (shifted - {1'b0, r_dvs}) : shifted;
            r_quo <= {r_quo[30:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1) && !i_start;
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

endmodule

// ===== hdl/wsp_parse.sv =====
module wsp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  wsp_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output wsp_pkg::t_result o_result
);

    wsp_pkg::t_phase  r_phase, n_phase;
    wsp_pkg::t_calc   r_calc, n_calc;
    logic [4:0]       r_pos, n_pos;
    logic [31:0]      r_tag, n_tag;
    logic [31:0]      r_len, n_len;
    logic [32:0]      r_skip, n_skip;
    logic [15:0]      r_afmt, n_afmt;
    logic [15:0]      r_ch, n_ch;
    logic [31:0]      r_rate, n_rate;
    logic [15:0]      r_bits, n_bits;
    logic [15:0]      r_extlen, n_extlen;
    logic [15:0]      r_subfmt, n_subfmt;
    logic             r_seen, n_seen;
    logic [7:0]       r_low, n_low;
    logic [15:0]      r_cur, n_cur;
    logic [31:0]      r_samples, n_samples;
    logic             r_err, n_err;
    logic             r_ov, n_ov;
    wsp_pkg::t_result r_res, n_res;

    logic        out_free;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;
    logic [47:0] product;

    assign out_free = !r_ov || !i_stall;
    assign o_pop    = i_valid && (r_calc == wsp_pkg::CALC_IDLE) && out_free;
    assign o_valid  = r_ov;
    assign o_result = r_res;
    assign product  = div_quo * r_ch;

    // frames = len / (2 * channels)
    wsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_len),
        .i_divisor  ({n_ch, 1'b0}),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Byte parser and header calculation sequencer
    always_comb begin
        logic [4:0]  p;
        logic [7:0]  b;
        logic [15:0] f;
        logic [32:0] amt;
        n_phase   = r_phase;
        n_calc    = r_calc;
        n_pos     = r_pos;
        n_tag     = r_tag;
        n_len     = r_len;
        n_skip    = r_skip;
        n_afmt    = r_afmt;
        n_ch      = r_ch;
        n_rate    = r_rate;
        n_bits    = r_bits;
        n_extlen  = r_extlen;
        n_subfmt  = r_subfmt;
        n_seen    = r_seen;
        n_low     = r_low;
        n_cur     = r_cur;
        n_samples = r_samples;
        n_err     = r_err;
        n_ov      = r_ov && i_stall;
        n_res     = r_res;
        div_start = 1'b0;
        b         = i_item.data_byte;
        p         = 5'd0;
        f         = 16'd0;
        amt       = 33'd0;

        case (r_calc)
            wsp_pkg::CALC_DIV: begin
                if (div_done) begin
                    n_calc = wsp_pkg::CALC_MUL;
                end
            end
            wsp_pkg::CALC_MUL: begin
                n_samples = product[31:0];
                n_calc    = wsp_pkg::CALC_EMIT;
            end
            wsp_pkg::CALC_EMIT: begin
                if (out_free) begin
                    n_calc  = wsp_pkg::CALC_IDLE;
                    n_cur   = 16'd0;
                    n_pos   = 5'd0;
                    n_phase = (r_samples != 32'd0) ? wsp_pkg::PH_DATA : wsp_pkg::PH_DONE;
                    n_ov    = 1'b1;
                    n_res   = '0;
                    n_res.kind          = wsp_pkg::KIND_HDR;
                    n_res.sample_rate   = r_rate;
                    n_res.channel_count = r_ch;
                    n_res.last_sample   = (r_samples == 32'd0);
                end
            end
            default: begin
            end
        endcase

        if (o_pop) begin
            // File start clears the parser before this byte is handled
            if (i_item.file_start) begin
                n_phase   = wsp_pkg::PH_SIG;
                n_pos     = 5'd0;
                n_tag     = 32'd0;
                n_len     = 32'd0;
                n_skip    = 33'd0;
                n_afmt    = 16'd0;
                n_ch      = 16'd0;
                n_rate    = 32'd0;
                n_bits    = 16'd0;
                n_extlen  = 16'd0;
                n_subfmt  = 16'd0;
                n_seen    = 1'b0;
                n_low     = 8'd0;
                n_cur     = 16'd0;
                n_samples = 32'd0;
                n_err     = 1'b0;
            end
            p = n_pos;
            if (!n_err) begin
                n_res = '0;
                case (n_phase)
                    wsp_pkg::PH_SIG: begin
                        n_pos = p + 5'd1;
                        if (p < 5'd4 || (p >= 5'd8 && p < 5'd12)) begin
                            n_tag = {n_tag[23:0], b};
                        end
                        if (p == 5'd3 && n_tag != wsp_pkg::TAG_RIFF) begin
                            n_err = 1'b1;
                            n_ov  = 1'b1;
                            n_res.kind       = wsp_pkg::KIND_ERR;
                            n_res.error_code = wsp_pkg::ERR_RIFF;
                        end else if (p == 5'd11) begin
                            if (n_tag != wsp_pkg::TAG_WAVE) begin
                                n_err = 1'b1;
                                n_ov  = 1'b1;
                                n_res.kind       = wsp_pkg::KIND_ERR;
                                n_res.error_code = wsp_pkg::ERR_WAVE;
                            end else begin
                                n_phase = wsp_pkg::PH_CHDR;
                                n_pos   = 5'd0;
                            end
                        end
                    end
                    wsp_pkg::PH_CHDR: begin
                        n_pos = p + 5'd1;
                        if (p < 5'd4) begin
                            n_tag = {n_tag[23:0], b};
                        end else begin
                            if (p == 5'd4) begin
                                n_len = 32'd0;
                            end
                            n_len[p[1:0]*8 +: 8] = n_len[p[1:0]*8 +: 8] | b;
                        end
                        if (p >= 5'd7) begin
                            n_pos = 5'd0;
                            f = n_afmt;
                            if (n_afmt == wsp_pkg::FMT_EXT && n_subfmt == wsp_pkg::FMT_PCM) begin
                                f = wsp_pkg::FMT_PCM;
                            end
                            if (n_tag == wsp_pkg::TAG_FMT) begin
                                n_phase = wsp_pkg::PH_FMT;
                            end else if (n_tag == wsp_pkg::TAG_DATA) begin
                                n_res.kind = wsp_pkg::KIND_ERR;
                                if (!n_seen) begin
                                    n_err = 1'b1;
                                    n_res.error_code = wsp_pkg::ERR_NO_FMT;
                                end else if (f != wsp_pkg::FMT_PCM) begin
                                    n_err = 1'b1;
                                    n_res.error_code = wsp_pkg::ERR_NOT_PCM;
                                end else if (n_ch == 16'd0) begin
                                    n_err = 1'b1;
                                    n_res.error_code = wsp_pkg::ERR_NO_CH;
                                end else if (n_bits != wsp_pkg::BITS_16) begin
                                    n_err = 1'b1;
                                    n_res.error_code = wsp_pkg::ERR_BITS;
                                end else begin
                                    div_start = 1'b1;
                                    n_calc    = wsp_pkg::CALC_DIV;
                                end
                                n_ov = n_err;
                            end else begin
                                amt     = {1'b0, n_len} + {32'd0, n_len[0]};
                                n_skip  = amt;
                                n_phase = (amt != 33'd0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CHDR;
                            end
                        end
                    end
                    wsp_pkg::PH_FMT: begin
                        n_pos = p + 5'd1;
                        if (p < 5'd2) begin
                            n_afmt = wsp_pkg::put16(n_afmt, p[0], b);
                        end else if (p < 5'd4) begin
                            n_ch = wsp_pkg::put16(n_ch, p[0], b);
                        end else if (p < 5'd8) begin
                            n_rate[p[1:0]*8 +: 8] = b;
                        end else if (p >= 5'd14) begin
                            n_bits = wsp_pkg::put16(n_bits, p[0], b);
                        end
                        if (p >= 5'd15) begin
                            n_seen = 1'b1;
                            n_pos  = 5'd0;
                            if (n_afmt == wsp_pkg::FMT_EXT) begin
                                n_phase = wsp_pkg::PH_FMTX;
                            end else begin
                                amt = (n_len > 32'd16) ? {1'b0, n_len - 32'd16} : 33'd0;
                                amt = amt + {32'd0, n_len[0]};
                                n_skip  = amt;
                                n_phase = (amt != 33'd0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CHDR;
                            end
                        end
                    end
                    wsp_pkg::PH_FMTX: begin
                        n_pos = p + 5'd1;
                        if (p < 5'd2) begin
                            n_extlen = wsp_pkg::put16(n_extlen, p[0], b);
                        end else if (p == 5'd8 || p == 5'd9) begin
                            n_subfmt = wsp_pkg::put16(n_subfmt, p[0], b);
                        end
                        if (p >= 5'd23) begin
                            if (n_extlen != wsp_pkg::EXT_SIZE) begin
                                n_err = 1'b1;
                                n_ov  = 1'b1;
                                n_res.kind       = wsp_pkg::KIND_ERR;
                                n_res.error_code = wsp_pkg::ERR_EXT;
                            end else begin
                                n_pos = 5'd0;
                                amt = (n_len > 32'd40) ? {1'b0, n_len - 32'd40} : 33'd0;
                                amt = amt + {32'd0, n_len[0]};
                                n_skip  = amt;
                                n_phase = (amt != 33'd0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CHDR;
                            end
                        end
                    end
                    wsp_pkg::PH_SKIP: begin
                        if (n_skip != 33'd0) begin
                            n_skip = n_skip - 33'd1;
                        end
                        if (n_skip == 33'd0) begin
                            n_phase = wsp_pkg::PH_CHDR;
                            n_pos   = 5'd0;
                        end
                    end
                    wsp_pkg::PH_DATA: begin
                        n_pos = {4'd0, ~p[0]};
                        if (!p[0]) begin
                            n_low = b;
                        end else begin
                            n_cur = n_cur + 16'd1;
                            if (n_cur >= n_ch) begin
                                n_cur = 16'd0;
                            end
                            if (n_samples != 32'd0) begin
                                n_samples = n_samples - 32'd1;
                            end
                            if (n_samples == 32'd0) begin
                                n_phase = wsp_pkg::PH_DONE;
                            end
                            n_ov = 1'b1;
                            n_res.kind          = wsp_pkg::KIND_SAMPLE;
                            n_res.sample_value  = {b, n_low};
                            n_res.channel_index = r_cur;
                            n_res.last_sample   = (n_samples == 32'd0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsp_pkg::PH_SIG;
            r_calc    <= wsp_pkg::CALC_IDLE;
            r_pos     <= 5'd0;
            r_tag     <= 32'd0;
            r_len     <= 32'd0;
            r_skip    <= 33'd0;
            r_afmt    <= 16'd0;
            r_ch      <= 16'd0;
            r_rate    <= 32'd0;
            r_bits    <= 16'd0;
            r_extlen  <= 16'd0;
            r_subfmt  <= 16'd0;
            r_seen    <= 1'b0;
            r_low     <= 8'd0;
            r_cur     <= 16'd0;
            r_samples <= 32'd0;
            r_err     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_calc    <= n_calc;
            r_pos     <= n_pos;
            r_tag     <= n_tag;
            r_len     <= n_len;
            r_skip    <= n_skip;
            r_afmt    <= n_afmt;
            r_ch      <= n_ch;
            r_rate    <= n_rate;
            r_bits    <= n_bits;
            r_extlen  <= n_extlen;
            r_subfmt  <= n_subfmt;
            r_seen    <= n_seen;
            r_low     <= n_low;
            r_cur     <= n_cur;
            r_samples <= n_samples;
            r_err     <= n_err;
            r_ov      <= n_ov;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_no_pop_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calc != wsp_pkg::CALC_IDLE |-> !o_pop)
        else $error("byte taken during header calculation");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_calc == wsp_pkg::CALC_DIV)
        else $error("divider finished outside division step");

    a_data_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsp_pkg::PH_DATA |-> r_samples != 32'd0 && r_cur < r_ch)
        else $error("data phase with no samples left or bad channel");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(o_pop && i_item.file_start) |=> !(r_ov && !$past(r_ov))
                                                    || $past(r_calc) == wsp_pkg::CALC_EMIT)
        else $error("result raised while error latched");

endmodule

// ===== hdl/wav_stream_parser.sv =====
// WAV byte stream parser for 16-bit PCM.
// Input channel: one file byte per transfer on i_data_byte, with i_file_start
// set on the first byte of a file (restarts the parser). Accepted when
// i_valid is high and o_stall is low; a four-entry queue takes bytes while
// the parser or the result side is busy.
// Output channel: one result per transfer when o_valid is high and i_stall
// is low: a header (rate, channel count), then the samples in interleaved
// order with channel tags and a last flag, or one error code. After an error
// no results come until the next file start.
// Path: a byte is written into the queue on acceptance and taken by the
// parser from the queue head; its result is registered in the output
// register. The header result follows the division, multiply and emit steps.
// Throughput: one byte per cycle while the output is not stalled, except at
// the data chunk header, where the sample count is computed by a bit-serial
// divider and a multiply, holding the parser; the queue then fills and
// o_stall rises.
// Reset: synchronous, active low; clears the queue, the parser and the
// output valid. A stalled result holds, and the parser takes no byte while
// the output register is full and stalled.
module wav_stream_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_file_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample_value,
    output logic [15:0]        o_channel_index,
    output logic [31:0]        o_sample_rate,
    output logic [15:0]        o_channel_count,
    output logic [2:0]         o_error_code,
    output logic               o_last_sample
);

    wsp_pkg::t_item   in_item, q_item;
    wsp_pkg::t_result res;
    logic             q_valid, q_pop;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.file_start = i_file_start;

    // Front: byte queue
    wsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // Back: parser and result register
    wsp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (res)
    );

    assign o_kind          = res.kind;
    assign o_sample_value  = res.sample_value;
    assign o_channel_index = res.channel_index;
    assign o_sample_rate   = res.sample_rate;
    assign o_channel_count = res.channel_count;
    assign o_error_code    = res.error_code;
    assign o_last_sample   = res.last_sample;

endmodule
